// File: hdl/qgsu_pkg.sv
// shared types, constants and helpers for the qubit gate state update core
package qgsu_pkg;

  localparam int NUM_QUBITS = 10;
  localparam int AMP_WIDTH  = 16;
  localparam int DIM        = 1 << NUM_QUBITS;
  localparam int IDX_W      = NUM_QUBITS;
  localparam int FRAC       = 14;
  localparam int ACC_W      = 40;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_APPLY = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // input tdata layout, highest bit first
  typedef struct packed {
    logic [9:0]         basis_index;
    logic signed [15:0] sin_half;
    logic signed [15:0] cos_half;
    logic               rotate;
    logic [3:0]         target_b;
    logic [3:0]         target_a;
    logic [1:0]         arity;
    logic signed [15:0] entry_im;
    logic signed [15:0] entry_re;
    logic [1:0]         col;
    logic [1:0]         row;
    logic [1:0]         operation;
  } in_item_t;

  // round half up by FRAC bits, saturate to 16 bits signed
  function automatic logic signed [15:0] rnd_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + (ACC_W'(1) <<< (FRAC - 1))) >>> FRAC;
    if (t > ACC_W'(32767)) rnd_sat = 16'sh7fff;
    else if (t < -ACC_W'(32768)) rnd_sat = 16'sh8000;
    else rnd_sat = t[15:0];
  endfunction

endpackage

// File: hdl/qgsu_cmac.sv
// shared complex multiply-accumulate unit, one complex product per cycle while en is high
module qgsu_cmac (
  input  logic                                 clk,
  input  logic                                 clr,
  input  logic                                 en,
  input  logic signed [15:0]                   a_re,
  input  logic signed [15:0]                   a_im,
  input  logic signed [15:0]                   b_re,
  input  logic signed [15:0]                   b_im,
  output logic signed [qgsu_pkg::ACC_W-1:0]    acc_re,
  output logic signed [qgsu_pkg::ACC_W-1:0]    acc_im
);
  import qgsu_pkg::*;

  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0] p_re, p_im;
  logic signed [31:0]      p_rr, p_ii, p_ri, p_ir;

  // full 32-bit partial products, combined at accumulator width
  always_comb begin
    p_rr = a_re * b_re;
    p_ii = a_im * b_im;
    p_ri = a_re * b_im;
    p_ir = a_im * b_re;
    p_re = ACC_W'(p_rr) - ACC_W'(p_ii);
    p_im = ACC_W'(p_ri) + ACC_W'(p_ir);
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (clr) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (en) begin
      acc_re_r <= acc_re_r + p_re;
      acc_im_r <= acc_im_r + p_im;
    end
  end

  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;
endmodule

// File: hdl/qubit_gate_state_update_core.sv
// top level: amplitude memory, gate matrix, sequencer around one complex mac
// Each request is taken when in_tready is high; the core then works alone until done.
// A matrix write is stored when it is taken. A read passes through S_RD and S_RD2, presents
// its result and keeps in_tready low until the result is taken. A state reset sweeps all
// 1024 entries (also done once after reset before the first request). An apply scans
// every base index, skipping each index with a target bit set; for each group of m members
// (2 for arity one, 4 for arity two) it loads the m amplitudes over the single memory read
// port, then per output row accumulates m products in the shared complex multiply-accumulate
// and writes the row back.
// With rotate set, the 16 gate entries are first recomputed, one per cycle.
// An apply with a target out of range or equal targets is dropped when it is taken.
module qubit_gate_state_update_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation, row, col, entry_re, entry_im, arity, target_a, target_b, rotate,
  // cos_half, sin_half, basis_index (91 bits, padded to 96)
  input  logic [95:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // amp_re, amp_im, index_echo, zero fill
  output logic [47:0]  out_tdata
);
  import qgsu_pkg::*;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_GROT  = 9'b000000100,
    S_GFIND = 9'b000001000,
    S_LOAD  = 9'b000010000,
    S_MAC   = 9'b000100000,
    S_WB    = 9'b001000000,
    S_RD    = 9'b010000000,
    S_RD2   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  in_item_t req;
  assign req = in_item_t'(in_tdata[90:0]);

  // storage
  logic [31:0] amem [DIM];
  logic [31:0] gmat [16];
  logic [31:0] geff_r [16];
  logic [31:0] rd_data_r;
  logic signed [15:0] old_re_r [4];
  logic signed [15:0] old_im_r [4];

  // request fields held during work
  logic [1:0]  n_r;        // member count minus one (1 or 3)
  logic [3:0]  ta_r, tb_r;
  logic        rot_r;
  logic signed [15:0] c_r, s_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_hold_r;
  logic [IDX_W:0]   base_r;
  logic [1:0]  k_r, r_r;
  logic [3:0]  ge_r;
  logic        ld_v_r;
  logic [1:0]  ld_k_r;

  logic [IDX_W-1:0] mask_w;
  logic [IDX_W-1:0] off_w [4];
  logic [IDX_W-1:0] addr_k;

  logic out_valid_r;
  logic [47:0] out_data_r;

  // group offsets
  always_comb begin
    mask_w = IDX_W'(1) << ta_r;
    if (n_r == 2'd3) mask_w = mask_w | (IDX_W'(1) << tb_r);
    for (int k = 0; k < 4; k++) begin
      off_w[k] = (k[0] ? (IDX_W'(1) << ta_r) : '0) | (k[1] ? (IDX_W'(1) << tb_r) : '0);
    end
    addr_k = base_r[IDX_W-1:0] | off_w[k_r];
  end

  // complex mac hookup
  logic mac_clr, mac_en;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  logic [31:0] gsel;
  always_comb gsel = geff_r[{r_r, k_r}];
  qgsu_cmac u_mac (
    .clk(clk), .clr(mac_clr), .en(mac_en),
    .a_re(gsel[15:0]), .a_im(gsel[31:16]),
    .b_re(old_re_r[k_r]), .b_im(old_im_r[k_r]),
    .acc_re(acc_re), .acc_im(acc_im)
  );

  // rotation entry
  logic [31:0] graw;
  logic signed [31:0] rot_p_re, rot_p_im;
  logic signed [ACC_W-1:0] rot_re, rot_im;
  always_comb begin
    graw     = gmat[ge_r];
    rot_p_re = s_r * $signed(graw[31:16]);
    rot_p_im = s_r * $signed(graw[15:0]);
    rot_re = ((ge_r[3:2] == ge_r[1:0]) ? (ACC_W'(c_r) <<< FRAC) : '0)
             + ACC_W'(rot_p_re);
    rot_im = -ACC_W'(rot_p_im);
  end

  logic start_apply_ok;
  always_comb begin
    start_apply_ok = req.target_a < 4'(NUM_QUBITS);
    if (req.arity[1] && (req.target_b >= 4'(NUM_QUBITS) || req.target_b == req.target_a))
      start_apply_ok = 1'b0;
  end

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  logic accept;
  assign accept = in_tvalid && in_tready;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    mac_clr = 1'b0;
    mac_en  = 1'b0;
    unique case (state_r)
      S_CLR:   if (idx_r == IDX_W'(DIM - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            OP_WRITE: state_nxt = S_IDLE;
            OP_APPLY: state_nxt = start_apply_ok ? (req.rotate ? S_GROT : S_GFIND) : S_IDLE;
            OP_RESET: state_nxt = S_CLR;
            OP_READ:  state_nxt = S_RD;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_GROT:  if (ge_r == 4'hf) state_nxt = S_GFIND;
      S_GFIND: begin
        if (base_r[IDX_W]) state_nxt = S_IDLE;
        else if ((base_r[IDX_W-1:0] & mask_w) == '0) state_nxt = S_LOAD;
      end
      S_LOAD: if (ld_v_r && ld_k_r == n_r) begin
        state_nxt = S_MAC;
        mac_clr = 1'b1;
      end
      S_MAC: begin
        mac_en = 1'b1;
        if (k_r == n_r) state_nxt = S_WB;
      end
      S_WB: begin
        mac_clr = 1'b1;
        state_nxt = (r_r == n_r) ? S_GFIND : S_MAC;
      end
      S_RD:    state_nxt = S_RD2;
      S_RD2:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) idx_r <= idx_r + 1'b1;
      else if (accept) idx_r <= '0;
      if (state_r == S_RD2) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      n_r   <= req.arity[1] ? 2'd3 : 2'd1;
      ta_r  <= req.target_a;
      tb_r  <= req.target_b;
      rot_r <= req.rotate;
      c_r   <= req.cos_half;
      s_r   <= req.sin_half;
      ge_r  <= '0;
      base_r <= '0;
      k_r   <= '0;
      r_r   <= '0;
      if (req.operation == OP_WRITE) gmat[{req.row, req.col}] <= {req.entry_im, req.entry_re};
      // plain gate copy
      for (int e = 0; e < 16; e++) geff_r[e] <= gmat[e];
    end
    case (state_r)
      S_GROT: begin
        geff_r[ge_r] <= {rnd_sat(rot_im), rnd_sat(rot_re)};
        ge_r <= ge_r + 1'b1;
      end
      S_GFIND: begin
        if ((base_r[IDX_W-1:0] & mask_w) != '0) base_r <= base_r + 1'b1;
        k_r <= '0;
        r_r <= '0;
        ld_v_r <= 1'b0;
      end
      S_LOAD: begin
        // issue reads k_r, capture previous one
        if (ld_v_r) begin
          old_re_r[ld_k_r] <= rd_data_r[15:0];
          old_im_r[ld_k_r] <= rd_data_r[31:16];
        end
        if (ld_v_r && ld_k_r == n_r) begin
          ld_v_r <= 1'b0;
          k_r <= '0;
        end else begin
          ld_v_r <= 1'b1;
          ld_k_r <= k_r;
          if (k_r != n_r) k_r <= k_r + 1'b1;
        end
      end
      S_MAC: if (k_r != n_r) k_r <= k_r + 1'b1;
      S_WB: begin
        k_r <= '0;
        r_r <= r_r + 1'b1;
        if (r_r == n_r) base_r <= base_r + 1'b1;
      end
      S_RD2: out_data_r <= {6'd0, idx_hold_r, rd_data_r};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) idx_hold_r <= req.basis_index[IDX_W-1:0];
  end

  // amplitude memory: one write, one registered read
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [31:0]       wdata;
  always_comb begin
    we = 1'b0;
    waddr = idx_r;
    wdata = '0;
    raddr = (state_r == S_RD) ? idx_hold_r : addr_k;
    if (state_r == S_CLR) begin
      we = 1'b1;
      wdata = (idx_r == '0) ? 32'(1 << (AMP_WIDTH - 2)) : '0;
    end else if (state_r == S_WB) begin
      we = 1'b1;
      waddr = base_r[IDX_W-1:0] | off_w[r_r];
      wdata = {rnd_sat(acc_im), rnd_sat(acc_re)};
    end
  end
  always_ff @(posedge clk) begin
    if (we) amem[waddr] <= wdata;
    rd_data_r <= amem[raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule

// File: hdl/qgsu_checker.sv
// port-level checks for the qubit gate state update core
module qgsu_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata
);
  // no new request taken while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("request taken with pending result");
  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("result dropped");
  // echo index has zero fill
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:42] == 6'd0) else $error("bad fill");
  // a result never shows up in the cycle right after a request is taken
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid) else $error("result too early");
  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready) else $error("activity after reset");
endmodule

bind qubit_gate_state_update_core qgsu_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
